/* rtl/core/ile_pkg.sv */
package ile_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned COUNT_W = 6;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned STAT_W  = 2;

    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic               ins;
        logic               del;
        logic [INDEX_W-1:0] idx;
        logic [DATA_W-1:0]  value;
    } t_cell_cmd;

endpackage

/* rtl/core/ile_if.sv */
interface ile_req_if import ile_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic [INDEX_W-1:0]       index;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface ile_rsp_if import ile_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       item_count;

    modport source (output valid, output read_value, output status, output item_count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input item_count,
                    output ready);
endinterface

/* rtl/core/ile_cell.sv */
module ile_cell import ile_pkg::*; #(
    parameter int unsigned CAPACITY = 32,
    parameter int unsigned POS      = 0
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_data,
    output logic              o_hit
);

    localparam int unsigned POS_W = ($clog2(CAPACITY) > 0) ? $clog2(CAPACITY) : 1;
    localparam int unsigned PW    = (POS_W > INDEX_W) ? POS_W : INDEX_W;
    localparam logic [PW-1:0] POS_V = PW'(POS);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic [PW-1:0]     idx_e;

    assign idx_e = PW'(i_cmd.idx);
    assign o_hit = (POS_V == idx_e);

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (POS_V > idx_e) begin
                n_data = i_left;
            end else if (POS_V == idx_e) begin
                n_data = i_cmd.value;
            end
        end else if (i_cmd.del) begin
            if (POS_V >= idx_e) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* rtl/core/indexed_list_engine.sv */
// indexed_list_engine: bounded ordered list of signed 32-bit words
// i_req carries a request (op, index, value); o_rsp returns one response
// per request with read_value, status and item_count after the request.
// op read returns the word at index, insert places value before index
// (index equal to the count appends), delete removes the word at index.
// storage is a row of CAPACITY cells; an insert or delete moves every
// cell past the index one place in the same cycle, so a request is taken
// each cycle unless o_rsp stalls; the response is registered at acceptance.
// sustained rate: one request per cycle while the receiver takes each
// response, set by the cell row and the response register.
// reset clears the count and the response valid; cell contents are not
// cleared and only positions below the count are ever read.
// when the receiver stalls, the response register holds and i_req.ready
// drops until the response is taken; a response leaving in the same cycle
// frees the register for the next request.
module indexed_list_engine import ile_pkg::*; #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ile_req_if.sink       i_req,
    ile_rsp_if.source     o_rsp
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam logic [EW-1:0] CAP_V = EW'(CAPACITY);

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_rsp_valid;
    logic [DATA_W-1:0]    r_read_value;
    logic [DATA_W-1:0]    n_read_value;
    logic [STAT_W-1:0]    r_status;
    logic [STAT_W-1:0]    n_status;
    logic [COUNT_W-1:0]   r_item_count;
    logic [EW-1:0]        cnt_e;
    logic [EW-1:0]        idx_e;
    logic [EW-1:0]        next_e;
    logic                 accept;
    logic                 do_ins;
    logic                 do_del;
    logic [DATA_W-1:0]    rd_sel;
    t_cell_cmd            cmd;
    logic [DATA_W-1:0]    cell_data [CAPACITY];
    logic [CAPACITY-1:0]  cell_hit;

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign cnt_e       = EW'(r_count);
    assign idx_e       = EW'(i_req.index);

    assign do_ins = accept && (i_req.op == OP_INSERT) && (idx_e <= cnt_e) && (cnt_e < CAP_V);
    assign do_del = accept && (i_req.op == OP_DELETE) && (idx_e < cnt_e);

    assign cmd.ins   = do_ins;
    assign cmd.del   = do_del;
    assign cmd.idx   = i_req.index;
    assign cmd.value = i_req.value;

    for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;
        if (j == 0) begin : g_head
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[j-1];
        end
        if (j == CAPACITY - 1) begin : g_tail
            assign right_d = cell_data[j];
        end else begin : g_mid_r
            assign right_d = cell_data[j+1];
        end
        ile_cell #(
            .CAPACITY (CAPACITY),
            .POS      (j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_data[j]),
            .o_hit   (cell_hit[j])
        );
    end

    always_comb begin
        rd_sel = '0;
        for (int j = 0; j < CAPACITY; j++) begin
            if (cell_hit[j]) begin
                rd_sel = rd_sel | cell_data[j];
            end
        end
    end

    always_comb begin
        n_count      = r_count;
        n_read_value = '0;
        n_status     = ST_DONE;
        case (i_req.op)
            OP_READ: begin
                if (idx_e < cnt_e) begin
                    n_read_value = rd_sel;
                end else begin
                    n_read_value = '1;
                    n_status     = ST_RANGE;
                end
            end
            OP_INSERT: begin
                if (idx_e > cnt_e) begin
                    n_status = ST_RANGE;
                end else if (cnt_e >= CAP_V) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_DELETE: begin
                if (idx_e < cnt_e) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    assign next_e = EW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
            r_item_count <= next_e[COUNT_W-1:0];
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.read_value = r_read_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.item_count = r_item_count;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        EW'(r_count) <= CAP_V)
        else $error("list count above capacity");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow count");

    a_del_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_del |=> (r_count == $past(r_count) - CW'(1)))
        else $error("delete did not shrink count");

    a_no_move_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("count changed without request");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && (r_status == ST_FULL)) |-> (r_read_value == '0))
        else $error("dropped insert returned data");
`endif

endmodule
